FILE: rtl/urxrb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the serial receive FIFO with notification.
// No dependencies; imported by the front end, the back end and the top level.

package urxrb_pkg;

    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 7;
    localparam int MAX_RESULTS = 64;
    localparam int Q_DEPTH     = 2;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    // Action codes on the input stream; the fourth code is unused.
    typedef enum logic [1:0] {
        ACT_RX   = 2'd0,
        ACT_GET  = 2'd1,
        ACT_READ = 2'd2
    } t_action;

    typedef enum logic {
        CMD_RX  = 1'b0,
        CMD_POP = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind              kind;
        logic [BYTE_W-1:0]      rx_byte;
        logic [CNT_W-1:0]       count;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              data_valid;
        logic              last;
        logic              notify;
        logic              dropped;
    } t_result;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_POP  = 1'b1
    } t_back_state;

endpackage

FILE: rtl/uart_rx_ring_buffer_notify_top.sv
`timescale 1ns / 1ps
// Top level of the serial receive FIFO: configuration registers and the
// front and back ends. Depends on urxrb_pkg, urxrb_front and urxrb_back.

// Receive FIFO of a serial port with a watermark and line-end notification.
// Each request on the slave stream carries an action in tuser: a received
// byte is stored in a ring of RING_DEPTH bytes (or dropped when the ring is
// full), a get pops one byte, and a read pops up to max_count bytes (at most
// 64), one result per byte with tlast on the final one. A received byte
// raises notify when notification is enabled and either the fill count is
// above half the depth or, with line-end detection on, a carriage return is
// followed by a line feed. A front end takes one request per cycle, while
// its queue is not full, into a two-entry command queue; the back end works
// on one command at a time. A received byte, or a pop that finds nothing to
// take, gives a single result; a pop of n bytes gives n results, read from
// the single registered read port of the ring memory one byte per cycle
// while the result stage is free. Each request passes through the command
// queue and then the registered result stage. A result that waits on tready
// holds the back end; the command queue keeps taking requests until it is full.
// The ring memory has no reset and needs no clearing pass: the fill count
// keeps unwritten entries from being read. Configuration registers are at
// byte address 0 (notify_enable, reset 0) and 4 (line_end_detect, reset 1).

module uart_rx_ring_buffer_notify_top
    import urxrb_pkg::*;
#(
    parameter int RING_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [14:8] max_count
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] data_byte
    output logic [2:0]  m_axis_tuser,   // [0] data_valid, [1] notify, [2] dropped
    output logic        m_axis_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_NOTIFY_ENABLE   = 1'b0;
    localparam logic REG_LINE_END_DETECT = 1'b1;

    logic    r_notify_enable;
    logic    r_line_end_detect;
    logic    w_cfg_wr;
    logic    w_cmd_valid;
    logic    w_cmd_ready;
    t_cmd    w_cmd;
    t_result w_result;

    // Registers are decoded on address bit 2 only; writes land in the access
    // cycle since the port never inserts wait states.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_notify_enable   <= 1'b0;
            r_line_end_detect <= 1'b1;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_NOTIFY_ENABLE:   r_notify_enable   <= pwdata[0];
                REG_LINE_END_DETECT: r_line_end_detect <= pwdata[0];
                default:             r_notify_enable   <= r_notify_enable;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_NOTIFY_ENABLE:   prdata[0] = r_notify_enable;
            REG_LINE_END_DETECT: prdata[0] = r_line_end_detect;
            default:             prdata    = '0;
        endcase
    end

    // Front end: classify each request and queue it as a command.
    urxrb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_rx_byte   (s_axis_tdata[7:0]),
        .i_max_count (s_axis_tdata[14:8]),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    // Back end: ring storage, notification and pop sequencing.
    urxrb_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (w_cmd_valid),
        .i_cmd             (w_cmd),
        .o_cmd_ready       (w_cmd_ready),
        .i_notify_enable   (r_notify_enable),
        .i_line_end_detect (r_line_end_detect),
        .o_out_valid       (m_axis_tvalid),
        .o_result          (w_result),
        .i_out_ready       (m_axis_tready)
    );

    assign m_axis_tdata    = w_result.data_byte;
    assign m_axis_tuser[0] = w_result.data_valid;
    assign m_axis_tuser[1] = w_result.notify;
    assign m_axis_tuser[2] = w_result.dropped;
    assign m_axis_tlast    = w_result.last;

endmodule

FILE: rtl/urxrb_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, turns them into commands and queues them.
// Depends on urxrb_pkg.

module urxrb_front
    import urxrb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_action,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic [CNT_W-1:0]  i_max_count,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_ready
);

    localparam int QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    t_cmd              r_q [Q_DEPTH];
    logic [QP_W-1:0]   r_wr_ptr;
    logic [QP_W-1:0]   r_rd_ptr;
    logic [QP_W:0]     r_cnt;

    t_cmd  w_cmd;
    logic  w_keep;
    logic  w_push;
    logic  w_pop;

    assign o_in_ready  = (r_cnt != (QP_W+1)'(Q_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    // A get is a pop of one byte; a read saturates at the result limit.
    always_comb begin
        w_keep        = 1'b1;
        w_cmd.kind    = CMD_RX;
        w_cmd.rx_byte = i_rx_byte;
        w_cmd.count   = '0;
        unique case (i_action)
            ACT_RX: begin
                w_cmd.kind = CMD_RX;
            end
            ACT_GET: begin
                w_cmd.kind  = CMD_POP;
                w_cmd.count = CNT_W'(1);
            end
            ACT_READ: begin
                w_cmd.kind  = CMD_POP;
                w_cmd.count = (i_max_count > CNT_W'(MAX_RESULTS)) ?
                              CNT_W'(MAX_RESULTS) : i_max_count;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign w_push = i_in_valid && o_in_ready && w_keep;
    assign w_pop  = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QP_W'(Q_DEPTH-1)) ? '0 : r_wr_ptr + QP_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QP_W'(Q_DEPTH-1)) ? '0 : r_rd_ptr + QP_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + (QP_W+1)'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - (QP_W+1)'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QP_W+1)'(Q_DEPTH))
        else $error("command queue count above its depth");
`endif

endmodule

FILE: rtl/urxrb_back.sv
`timescale 1ns / 1ps
// Back end: byte ring memory, fill tracking, notify logic and pop sequencer,
// with a registered result stage. Depends on urxrb_pkg.

module urxrb_back
    import urxrb_pkg::*;
#(
    parameter int RING_DEPTH = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_ready,
    input  logic    i_notify_enable,
    input  logic    i_line_end_detect,
    output logic    o_out_valid,
    output t_result o_result,
    input  logic    i_out_ready
);

    localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W  = (FILL_W > CNT_W) ? FILL_W : CNT_W;

    logic [BYTE_W-1:0] r_mem [RING_DEPTH];

    t_back_state       r_state, n_state;
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [BYTE_W-1:0] r_prev, n_prev;
    logic [CNT_W-1:0]  r_remain, n_remain;
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_out_valid;
    t_result           r_out;

    logic              w_out_free;
    logic              w_full;
    logic              w_mem_we;
    logic              w_rd_en;
    logic              w_load;
    t_result           w_res;
    logic [CMP_W-1:0]  w_fill_x;
    logic [CMP_W-1:0]  w_cnt_x;
    logic [CMP_W-1:0]  w_take_x;
    logic [CNT_W-1:0]  w_take;
    logic              w_last_pop;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_full     = (r_fill == FILL_W'(RING_DEPTH));
    assign w_fill_x   = CMP_W'(r_fill);
    assign w_cnt_x    = CMP_W'(i_cmd.count);
    assign w_take_x   = (w_fill_x < w_cnt_x) ? w_fill_x : w_cnt_x;
    assign w_take     = w_take_x[CNT_W-1:0];
    assign w_last_pop = (r_remain == CNT_W'(1));

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && w_out_free && i_cmd.kind == CMD_POP &&
                    w_take != '0) begin
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                if (w_out_free && w_last_pop) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath control and result formation.
    always_comb begin
        o_cmd_ready = 1'b0;
        w_mem_we    = 1'b0;
        w_rd_en     = 1'b0;
        w_load      = 1'b0;
        w_res       = '0;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_fill      = r_fill;
        n_prev      = r_prev;
        n_remain    = r_remain;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_ready = 1'b1;
                    if (i_cmd.kind == CMD_RX) begin
                        if (!w_full) begin
                            w_mem_we = 1'b1;
                            n_wr_ptr = (r_wr_ptr == PTR_W'(RING_DEPTH-1)) ?
                                       '0 : r_wr_ptr + PTR_W'(1);
                            n_fill   = r_fill + FILL_W'(1);
                        end
                        w_load        = 1'b1;
                        w_res.last    = 1'b1;
                        w_res.dropped = w_full;
                        w_res.notify  = i_notify_enable &&
                            ((n_fill > FILL_W'(RING_DEPTH/2)) ||
                             (i_line_end_detect && r_prev == CHAR_CR &&
                              i_cmd.rx_byte == CHAR_LF));
                        n_prev        = i_cmd.rx_byte;
                    end else if (w_take == '0) begin
                        w_load     = 1'b1;
                        w_res.last = 1'b1;
                    end else begin
                        w_rd_en  = 1'b1;
                        n_rd_ptr = (r_rd_ptr == PTR_W'(RING_DEPTH-1)) ?
                                   '0 : r_rd_ptr + PTR_W'(1);
                        n_fill   = r_fill - FILL_W'(1);
                        n_remain = w_take;
                    end
                end
            end
            ST_POP: begin
                if (w_out_free) begin
                    w_load           = 1'b1;
                    w_res.data_byte  = r_rd_data;
                    w_res.data_valid = 1'b1;
                    w_res.last       = w_last_pop;
                    if (!w_last_pop) begin
                        w_rd_en  = 1'b1;
                        n_rd_ptr = (r_rd_ptr == PTR_W'(RING_DEPTH-1)) ?
                                   '0 : r_rd_ptr + PTR_W'(1);
                        n_fill   = r_fill - FILL_W'(1);
                        n_remain = r_remain - CNT_W'(1);
                    end
                end
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_wr_ptr] <= i_cmd.rx_byte;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_fill      <= '0;
            r_prev      <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
            r_prev   <= n_prev;
            r_remain <= n_remain;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(RING_DEPTH))
        else $error("fill count above ring depth");

    a_pop_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) |-> (r_remain != '0))
        else $error("pop sequence running with nothing left to pop");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> (r_fill != '0))
        else $error("ring read issued while empty");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP && w_out_free) |=> (r_out_valid && r_out.data_valid))
        else $error("popped byte did not reach the result register");
`endif

endmodule
